// File: rtl/core/s2x_pkg.sv
// Package for the sRGB to XYZ (D50) converter: payload types, matrix
// coefficients and the elaboration-time builder of the linearization table.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package s2x_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [15:0] x_out;
    logic [15:0] y_out;
    logic [15:0] z_out;
  } result_t;

  localparam int unsigned LinW  = 31;
  localparam int unsigned CoefW = 23;
  localparam int unsigned ProdW = LinW + CoefW;
  localparam int unsigned AccW  = ProdW + 2;

  typedef logic [LinW-1:0]  lin_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef lin_t lin_table_t [256];

  localparam longint unsigned CoefScale = 64'd10000000;
  localparam int unsigned     RecipShift = 48;
  localparam longint unsigned Recip = (64'd1 << RecipShift) / CoefScale;
  localparam int unsigned     RecipW = 25;

  localparam coef_t XyzMatrix [3][3] = '{
    '{23'd4360747, 23'd3850649, 23'd1430804},
    '{23'd2225045, 23'd7168786, 23'd606169},
    '{23'd139322,  23'd971045,  23'd7141733}
  };

  function automatic longint unsigned fifth_power(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  function automatic longint unsigned lin_of(longint unsigned c);
    longint unsigned t30;
    longint unsigned s30;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (c <= 64'd10) begin
      return (c * 64'd10 * (64'd1 << 30) + 64'd16473) / 64'd32946;
    end
    t30 = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    s30 = (t30 * t30 + (64'd1 << 29)) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (fifth_power(mid) <= s30) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return (s30 * lo + (64'd1 << 29)) >> 30;
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = lin_t'(lin_of(longint'(i)));
    end
    return tbl;
  endfunction

endpackage

// File: rtl/core/s2x_linearize.sv
// Input register and sRGB transfer curve lookup for all three channels.
// Depends on s2x_pkg for the pixel type and the linearization table.
`timescale 1ns / 1ps

module s2x_linearize (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  s2x_pkg::pixel_t pixel_i,
  output logic            valid_o,
  output s2x_pkg::lin_t   lin_o [3]
);

  localparam s2x_pkg::lin_table_t LinTable = s2x_pkg::build_lin_table();

  logic            in_valid_q;
  s2x_pkg::pixel_t pixel_q;
  logic            lin_valid_q;
  s2x_pkg::lin_t   lin_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      lin_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= valid_i;
      lin_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pixel_q <= pixel_i;
    end
    lin_q[0] <= LinTable[pixel_q.red_in];
    lin_q[1] <= LinTable[pixel_q.green_in];
    lin_q[2] <= LinTable[pixel_q.blue_in];
  end

  assign valid_o = lin_valid_q;
  assign lin_o   = lin_q;

endmodule

// File: rtl/core/s2x_matrix.sv
// D50 matrix: nine registered products, then row sums with rounding offset.
// Depends on s2x_pkg for coefficient and width constants.
`timescale 1ns / 1ps

module s2x_matrix #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  s2x_pkg::lin_t                lin_i [3],
  output logic                         valid_o,
  output logic [OUT_FRAC_BITS+24:0]    sum_o [3]
);

  localparam int unsigned QW    = OUT_FRAC_BITS + 25;
  localparam int unsigned Shift = 30 - OUT_FRAC_BITS;
  localparam logic [QW-1:0] Half = QW'(s2x_pkg::CoefScale / 64'd2);

  logic                          prod_valid_q;
  logic                          sum_valid_q;
  logic [s2x_pkg::ProdW-1:0]     prod_q [3][3];
  logic [s2x_pkg::AccW-1:0]      acc [3];
  logic [QW-1:0]                 sum_d [3];
  logic [QW-1:0]                 sum_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      sum_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= s2x_pkg::ProdW'(lin_i[c]) * s2x_pkg::ProdW'(s2x_pkg::XyzMatrix[r][c]);
      end
    end
    sum_q <= sum_d;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = s2x_pkg::AccW'(prod_q[r][0]) + s2x_pkg::AccW'(prod_q[r][1])
             + s2x_pkg::AccW'(prod_q[r][2]);
      sum_d[r] = QW'(acc[r] >> Shift) + Half;
    end
  end

  assign valid_o = sum_valid_q;
  assign sum_o   = sum_q;

endmodule

// File: rtl/core/s2x_scale.sv
// Division of the row sums by the coefficient scale through a reciprocal
// estimate with one correction step, then saturation. Depends on s2x_pkg.
`timescale 1ns / 1ps

module s2x_scale #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [OUT_FRAC_BITS+24:0]    sum_i [3],
  output logic                         done_o,
  output s2x_pkg::result_t             result_o
);

  localparam int unsigned QW = OUT_FRAC_BITS + 25;
  localparam int unsigned EW = OUT_FRAC_BITS + 2;
  localparam int unsigned SH = OUT_FRAC_BITS - 7;
  localparam int unsigned NW = QW - SH;
  localparam int unsigned PW = NW + s2x_pkg::RecipW;
  localparam logic [PW-1:0] RecipP = PW'(s2x_pkg::Recip);
  localparam logic [QW-1:0] DivQ   = QW'(s2x_pkg::CoefScale);
  localparam logic [EW-1:0] OneE   = EW'(1) << OUT_FRAC_BITS;

  logic             est_valid_q;
  logic             done_q;
  logic [QW-1:0]    sum_q [3];
  logic [EW-1:0]    est_q [3];
  logic [PW-1:0]    prod [3];
  logic [QW-1:0]    rem [3];
  logic [EW-1:0]    quot [3];
  logic [15:0]      val_d [3];
  s2x_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      est_valid_q <= valid_i;
      done_q      <= est_valid_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod[r] = PW'(sum_i[r] >> SH) * RecipP;
      rem[r]  = sum_q[r] - QW'(est_q[r]) * DivQ;
      quot[r] = (rem[r] >= DivQ) ? est_q[r] + EW'(1) : est_q[r];
      val_d[r] = (quot[r] > OneE) ? 16'(OneE) : 16'(quot[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      est_q[r] <= EW'(prod[r] >> (s2x_pkg::RecipShift - SH));
    end
    sum_q          <= sum_i;
    result_q.x_out <= val_d[0];
    result_q.y_out <= val_d[1];
    result_q.z_out <= val_d[2];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  property est_within_one(int r);
    @(posedge clk_i) disable iff (!rst_ni)
      est_valid_q |-> (rem[r] < (DivQ << 1));
  endproperty

  assert property (est_within_one(0)) else $error("X quotient estimate off by more than one");
  assert property (est_within_one(1)) else $error("Y quotient estimate off by more than one");
  assert property (est_within_one(2)) else $error("Z quotient estimate off by more than one");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(est_valid_q))
    else $error("Result strobe without an item in the estimate stage");

endmodule

// File: rtl/core/srgb_to_xyz_converter_core.sv
// Top level of the sRGB to XYZ (D50) converter.
// Instantiates s2x_linearize, s2x_matrix and s2x_scale; uses s2x_pkg.
`timescale 1ns / 1ps
//
// Usage: drive pixel_i with the three 8-bit sRGB codes and raise start_i for
// one cycle per pixel. busy_o is always low, so a transfer takes place at
// every rising edge where start_i is high, one pixel per cycle sustained.
// Each pixel yields one result on result_o (X, Y, Z, unsigned fixed point
// with OUT_FRAC_BITS fraction bits, saturated at 1.0), marked by done_o for
// exactly one cycle. Six register stages are passed: input register, table
// lookup, matrix products, row sums, reciprocal estimate and corrected result
// register. Results come out in the order the pixels went in. The receiver
// must take each result in its strobe cycle; there is no stall path. Reset
// clears all stage valid flags, so no strobe appears for pixels in flight.
//
module srgb_to_xyz_converter_core #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  s2x_pkg::pixel_t  pixel_i,
  output logic             done_o,
  output s2x_pkg::result_t result_o
);

  logic                      lin_valid;
  s2x_pkg::lin_t             lin [3];
  logic                      sum_valid;
  logic [OUT_FRAC_BITS+24:0] sum [3];

  assign busy_o = 1'b0;

  s2x_linearize u_linearize (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .pixel_i (pixel_i),
    .valid_o (lin_valid),
    .lin_o   (lin)
  );

  s2x_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lin_valid),
    .lin_i   (lin),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  s2x_scale #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sum_valid),
    .sum_i    (sum),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
